[sv/spd_rx_pkg.sv]
package spd_rx_pkg;

    // Frame layout
    localparam int unsigned HDR_LEN   = 9;
    localparam int unsigned CKSUM_LEN = 2;
    localparam int unsigned ADDR_LEN  = 4;

    localparam logic [3:0] HDR_IDX_TYPE  = 4'd6;
    localparam logic [3:0] HDR_IDX_LENHI = 4'd7;
    localparam logic [3:0] HDR_IDX_LAST  = 4'(HDR_LEN - 1);
    localparam logic [3:0] HDR_IDX_ADDR0 = 4'd2;
    localparam logic [3:0] HDR_IDX_CHKEND = 4'(2 + ADDR_LEN);

    localparam logic [7:0] START_HI  = 8'hEF;
    localparam logic [7:0] START_LO  = 8'h01;
    localparam logic [7:0] TYPE_DATA = 8'h02;
    localparam logic [7:0] TYPE_ACK  = 8'h07;
    localparam logic [7:0] TYPE_END  = 8'h08;

    localparam logic [15:0] CKSUM_BYTES = 16'(CKSUM_LEN);

    // Register map reset values
    localparam logic [31:0] DEV_ADDR_RST = 32'hFFFF_FFFF;
    localparam logic [7:0]  ACK_CAP_RST  = 8'd16;
    localparam logic [15:0] DATA_CAP_RST = 16'd1024;

    typedef enum logic [1:0] {
        REG_DEV_ADDR = 2'd0,
        REG_ACK_CAP  = 2'd1,
        REG_DATA_CAP = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_START_ACK  = 2'd0,
        OP_START_DATA = 2'd1,
        OP_BYTE       = 2'd2,
        OP_TIMEOUT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HEADER     = 3'd1,
        PH_BODY       = 3'd2,
        PH_DRAIN_HDR  = 3'd3,
        PH_DRAIN_BODY = 3'd4
    } phase_t;

endpackage

[sv/sensor_packet_deframer_rx_core.sv]
// Receive-side deframer for a sensor reply link. Each input beat is one
// operation: start an acknowledge transaction, start a data transaction, a
// received byte, or a timeout. Every frame carries a 9-byte header (start code,
// 4-byte device address, packet type, big-endian length); payload bytes are
// forwarded one per output beat and the 2 checksum bytes are skipped without
// verification. A transaction closes with a single done beat carrying the
// status and, on success, the payload byte count. The block takes one input
// beat per clock: all decisions for a beat are combinational between the
// state registers and a single output register, and s_ready drops only while
// that output register holds a beat the sink has not taken. Registers sit at
// byte offsets 0x0 (device address), 0x4 (acknowledge capacity) and 0x8 (data
// capacity) and may only be written while no transaction is in progress.
module sensor_packet_deframer_rx_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_rx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [15:0] m_total_length
);
    import spd_rx_pkg::*;

    // configuration registers
    logic [31:0] dev_addr_reg;
    logic [7:0]  ack_cap_reg;
    logic [15:0] data_cap_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    // deframer state
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        data_mode_reg, data_mode_next;
    logic [15:0] byte_total_reg, byte_total_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_pvalid_reg;
    logic        out_done_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_total_reg;

    // result of the current beat
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_pvalid;
    logic        res_done;
    status_t     res_status;

    logic        accept;
    op_t         op;
    logic [7:0]  want_byte;
    logic        hdr_mismatch;
    logic [15:0] frame_len;
    logic [15:0] frame_span;
    logic [15:0] payload_len;
    logic [16:0] total_sum;
    logic [15:0] bytes_dec;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_DEV_ADDR: prdata = dev_addr_reg;
            REG_ACK_CAP:  prdata = {24'd0, ack_cap_reg};
            REG_DATA_CAP: prdata = {16'd0, data_cap_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RST;
            ack_cap_reg  <= ACK_CAP_RST;
            data_cap_reg <= DATA_CAP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEV_ADDR: dev_addr_reg <= pwdata;
                REG_ACK_CAP:  ack_cap_reg  <= pwdata[7:0];
                REG_DATA_CAP: data_cap_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_operation);

    // ---------------- header decode ----------------
    always_comb begin
        case (hdr_idx_reg)
            4'd0:    want_byte = START_HI;
            4'd1:    want_byte = START_LO;
            4'd2:    want_byte = dev_addr_reg[31:24];
            4'd3:    want_byte = dev_addr_reg[23:16];
            4'd4:    want_byte = dev_addr_reg[15:8];
            4'd5:    want_byte = dev_addr_reg[7:0];
            default: want_byte = 8'd0;
        endcase
    end

    assign hdr_mismatch = (hdr_idx_reg < HDR_IDX_CHKEND) && (s_rx_byte != want_byte);
    assign frame_len    = {len_hi_reg, s_rx_byte};
    // payload plus checksum; a length below the checksum size means no payload
    assign frame_span   = (frame_len < CKSUM_BYTES) ? CKSUM_BYTES : frame_len;
    assign payload_len  = frame_span - CKSUM_BYTES;
    assign total_sum    = {1'b0, byte_total_reg} + {1'b0, payload_len};
    assign bytes_dec    = bytes_left_reg - 16'd1;

    // ---------------- next state ----------------
    always_comb begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        hdr_bad_next    = hdr_bad_reg;
        frame_type_next = frame_type_reg;
        len_hi_next     = len_hi_reg;
        bytes_left_next = bytes_left_reg;
        data_mode_next  = data_mode_reg;
        byte_total_next = byte_total_reg;
        res_valid       = 1'b0;
        res_byte        = 8'd0;
        res_pvalid      = 1'b0;
        res_done        = 1'b0;
        res_status      = ST_OK;

        case (op)
            OP_START_ACK, OP_START_DATA: begin
                data_mode_next  = s_operation[0];
                phase_next      = PH_HEADER;
                hdr_idx_next    = 4'd0;
                hdr_bad_next    = 1'b0;
                frame_type_next = 8'd0;
                len_hi_next     = 8'd0;
                bytes_left_next = 16'd0;
                byte_total_next = 16'd0;
            end
            OP_TIMEOUT: begin
                if (phase_reg != PH_IDLE) begin
                    res_valid  = 1'b1;
                    res_done   = 1'b1;
                    phase_next = PH_IDLE;
                    if (phase_reg == PH_DRAIN_HDR || phase_reg == PH_DRAIN_BODY) begin
                        res_status = ST_OVERFLOW;
                    end else begin
                        res_status = ST_TIMEOUT;
                    end
                end
            end
            default: begin
                case (phase_reg)
                    PH_HEADER, PH_DRAIN_HDR: begin
                        if (phase_reg == PH_HEADER && hdr_mismatch) begin
                            hdr_bad_next = 1'b1;
                        end
                        if (hdr_idx_reg == HDR_IDX_TYPE) begin
                            frame_type_next = s_rx_byte;
                        end
                        if (hdr_idx_reg == HDR_IDX_LENHI) begin
                            len_hi_next = s_rx_byte;
                        end
                        if (hdr_idx_reg != HDR_IDX_LAST) begin
                            hdr_idx_next = hdr_idx_reg + 4'd1;
                        end else begin
                            hdr_idx_next    = 4'd0;
                            len_hi_next     = len_hi_reg;
                            bytes_left_next = frame_span;
                            if (phase_reg == PH_DRAIN_HDR) begin
                                phase_next = PH_DRAIN_BODY;
                            end else if (hdr_bad_reg) begin
                                res_valid  = 1'b1;
                                res_done   = 1'b1;
                                res_status = ST_BAD;
                                phase_next = PH_IDLE;
                            end else if (!data_mode_reg) begin
                                if (frame_type_reg != TYPE_ACK) begin
                                    res_valid  = 1'b1;
                                    res_done   = 1'b1;
                                    res_status = ST_BAD;
                                    phase_next = PH_IDLE;
                                end else if (payload_len > {8'd0, ack_cap_reg}) begin
                                    res_valid  = 1'b1;
                                    res_done   = 1'b1;
                                    res_status = ST_OVERFLOW;
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_BODY;
                                end
                            end else if (!(frame_type_reg inside {TYPE_DATA, TYPE_END})) begin
                                res_valid  = 1'b1;
                                res_done   = 1'b1;
                                res_status = ST_BAD;
                                phase_next = PH_IDLE;
                            end else if (total_sum > {1'b0, data_cap_reg}) begin
                                // swallow the rest of the transfer, then report overflow
                                phase_next = PH_DRAIN_BODY;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        bytes_left_next = bytes_dec;
                        if (bytes_left_reg > CKSUM_BYTES) begin
                            byte_total_next = byte_total_reg + 16'd1;
                            res_valid       = 1'b1;
                            res_pvalid      = 1'b1;
                            res_byte        = s_rx_byte;
                        end else if (bytes_dec == 16'd0) begin
                            if (!data_mode_reg || frame_type_reg == TYPE_END) begin
                                res_valid  = 1'b1;
                                res_done   = 1'b1;
                                res_status = ST_OK;
                                phase_next = PH_IDLE;
                            end else begin
                                hdr_idx_next = 4'd0;
                                hdr_bad_next = 1'b0;
                                phase_next   = PH_HEADER;
                            end
                        end
                    end
                    PH_DRAIN_BODY: begin
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == 16'd0) begin
                            if (frame_type_reg == TYPE_END) begin
                                res_valid  = 1'b1;
                                res_done   = 1'b1;
                                res_status = ST_OVERFLOW;
                                phase_next = PH_IDLE;
                            end else begin
                                hdr_idx_next = 4'd0;
                                phase_next   = PH_DRAIN_HDR;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign m_valid_next = (accept && res_valid) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hdr_idx_reg    <= 4'd0;
            hdr_bad_reg    <= 1'b0;
            frame_type_reg <= 8'd0;
            len_hi_reg     <= 8'd0;
            bytes_left_reg <= 16'd0;
            data_mode_reg  <= 1'b0;
            byte_total_reg <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg      <= phase_next;
                hdr_idx_reg    <= hdr_idx_next;
                hdr_bad_reg    <= hdr_bad_next;
                frame_type_reg <= frame_type_next;
                len_hi_reg     <= len_hi_next;
                bytes_left_reg <= bytes_left_next;
                data_mode_reg  <= data_mode_next;
                byte_total_reg <= byte_total_next;
            end
        end
    end

    // load the result beat; hold it while the sink stalls
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_byte_reg   <= res_byte;
            out_pvalid_reg <= res_pvalid;
            out_done_reg   <= res_done;
            out_status_reg <= res_status;
            out_total_reg  <= (res_done && res_status == ST_OK) ? byte_total_reg : 16'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_payload_valid = out_pvalid_reg;
    assign m_done_res      = out_done_reg;
    assign m_status        = out_status_reg;
    assign m_total_length  = out_total_reg;

    // ---------------- assertions ----------------
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload_valid != m_done_res))
        else $error("result beat must be either payload or done");

    a_len_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_total_length == 16'd0))
        else $error("total length reported with error status");

    a_hdr_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_idx_reg <= HDR_IDX_LAST)
        else $error("header index past end of header");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result beat is stalled");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid && res_done) |=> (phase_reg == PH_IDLE))
        else $error("transaction did not return to idle after done");

endmodule
